// File: rtl/core/pnfb_pkg.sv
// ---------------------------------------------------------------------------
// pnfb_pkg: shared types and constants of the packed nibble framebuffer
// Command codes, pixel operation kinds and the control structs passed
// between the sequencer, the read-modify-write stage and the top level.
// ---------------------------------------------------------------------------
package pnfb_pkg;

  // Width of the signed working coordinates: 11-bit start plus a 10-bit
  // extent needs 12 bits, one more keeps the corner terms clear of overflow.
  localparam int CW = 13;

  localparam logic [7:0] LO_MASK = 8'h0F;
  localparam logic [7:0] HI_MASK = 8'hF0;

  typedef enum logic [2:0] {
    MODE_CLEAR   = 3'd0,
    MODE_POINT   = 3'd1,
    MODE_HLINE   = 3'd2,
    MODE_VLINE   = 3'd3,
    MODE_FILL    = 3'd4,
    MODE_OUTLINE = 3'd5,
    MODE_OUTFILL = 3'd6,
    MODE_READ    = 3'd7
  } cmd_mode_t;

  typedef enum logic [1:0] {
    PK_NIBBLE = 2'd0,
    PK_BYTE   = 2'd1,
    PK_READ   = 2'd2
  } pix_kind_t;

  typedef struct packed {
    logic      valid;
    pix_kind_t kind;
    logic      hi;
    logic [3:0] color;
  } pix_ctl_t;

  typedef struct packed {
    logic       busy;
    logic       rd_valid;
    logic [7:0] rd_data;
  } rmw_stat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] read_byte;
    logic       outside;
  } res_t;

endpackage

// File: rtl/core/pnfb_ifs.sv
// ---------------------------------------------------------------------------
// pnfb_ifs: valid/ready channels of the framebuffer drawer
// Command channel and result channel, each with source and sink modports.
// ---------------------------------------------------------------------------
interface pnfb_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [10:0] x_pos;
  logic signed [10:0] y_pos;
  logic [9:0]        span_width;
  logic [9:0]        span_height;
  logic [3:0]        pen_color;
  logic [3:0]        fill_color;

  modport source (
    output valid, mode, x_pos, y_pos, span_width, span_height, pen_color, fill_color,
    input  ready
  );
  modport sink (
    input  valid, mode, x_pos, y_pos, span_width, span_height, pen_color, fill_color,
    output ready
  );
endinterface

interface pnfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_outside;

  modport source (
    output valid, read_byte, read_outside,
    input  ready
  );
  modport sink (
    input  valid, read_byte, read_outside,
    output ready
  );
endinterface

// File: rtl/core/pnfb_ram.sv
// ---------------------------------------------------------------------------
// pnfb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (old data on a
// collision with a write to the same address).
// ---------------------------------------------------------------------------
module pnfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/pnfb_rmw.sv
// ---------------------------------------------------------------------------
// pnfb_rmw: read-modify-write stage around the frame store
// Issue the read in the cycle an operation arrives, merge the nibble in the
// next cycle and write back; forward the previous write on a match.
// ---------------------------------------------------------------------------
module pnfb_rmw #(
  parameter int DEPTH = 10240,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  pnfb_pkg::pix_ctl_t  op_ctl,
  input  logic [AW-1:0]       op_addr,
  output pnfb_pkg::rmw_stat_t stat
);
  pnfb_pkg::pix_ctl_t s2;
  logic [AW-1:0]      s2_addr;
  logic               fwd_valid;
  logic [AW-1:0]      fwd_addr;
  logic [7:0]         fwd_data;
  logic [7:0]         ram_rdata;
  logic [7:0]         base;
  logic [7:0]         wdata;
  logic               we;

  pnfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (s2_addr),
    .wdata (wdata),
    .raddr (op_addr),
    .rdata (ram_rdata)
  );

  // The read of this beat raced the write of the beat before it.
  assign base = (fwd_valid && (fwd_addr == s2_addr)) ? fwd_data : ram_rdata;

  always_comb begin
    case (s2.kind)
      pnfb_pkg::PK_BYTE: wdata = {s2.color, s2.color};
      pnfb_pkg::PK_NIBBLE: begin
        if (s2.hi) begin
          wdata = (base & pnfb_pkg::LO_MASK) | {s2.color, 4'b0000};
        end else begin
          wdata = (base & pnfb_pkg::HI_MASK) | {4'b0000, s2.color};
        end
      end
      default: wdata = base;
    endcase
  end

  assign we = s2.valid && (s2.kind != pnfb_pkg::PK_READ);

  assign stat.busy     = s2.valid;
  assign stat.rd_valid = s2.valid && (s2.kind == pnfb_pkg::PK_READ);
  assign stat.rd_data  = base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s2.valid  <= op_ctl.valid;
      fwd_valid <= we;
    end
    s2.kind  <= op_ctl.kind;
    s2.hi    <= op_ctl.hi;
    s2.color <= op_ctl.color;
    s2_addr  <= op_addr;
    fwd_addr <= s2_addr;
    fwd_data <= wdata;
  end
endmodule

// File: rtl/core/pnfb_seq.sv
// ---------------------------------------------------------------------------
// pnfb_seq: command sequencer of the framebuffer drawer
// Break a command into clipped boxes, walk each box pixel by pixel, sweep
// the store for clear and after reset, and form the result beat.
// ---------------------------------------------------------------------------
module pnfb_seq #(
  parameter int SCREEN_WIDTH  = 160,
  parameter int SCREEN_HEIGHT = 128,
  localparam int STORE_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2,
  localparam int AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  pnfb_cmd_if.sink            cmd,
  output pnfb_pkg::pix_ctl_t  op_ctl,
  output logic [AW-1:0]       op_addr,
  input  pnfb_pkg::rmw_stat_t stat,
  input  logic                out_free,
  output pnfb_pkg::res_t      res
);
  localparam int LIN_W = AW + 1;
  localparam int X_W   = $clog2(SCREEN_WIDTH);
  localparam int Y_W   = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int CW    = pnfb_pkg::CW;

  localparam logic signed [CW-1:0] ZERO = '0;
  localparam logic signed [CW-1:0] ONE  = CW'(1);
  localparam logic signed [CW-1:0] XMAX = CW'(SCREEN_WIDTH - 1);
  localparam logic signed [CW-1:0] YMAX = CW'(SCREEN_HEIGHT - 1);

  localparam logic [2:0] BOX_TOP    = 3'd0;
  localparam logic [2:0] BOX_BOTTOM = 3'd1;
  localparam logic [2:0] BOX_LEFT   = 3'd2;
  localparam logic [2:0] BOX_RIGHT  = 3'd3;
  localparam logic [2:0] NBOX_ONE   = 3'd1;
  localparam logic [2:0] NBOX_OUTL  = 3'd4;
  localparam logic [2:0] NBOX_OFILL = 3'd5;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SWEEP   = 9'b000000010,
    S_SETUP   = 9'b000000100,
    S_MUL     = 9'b000001000,
    S_RUN     = 9'b000010000,
    S_RD      = 9'b000100000,
    S_RD_WAIT = 9'b001000000,
    S_DRAIN   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t              state;
  logic                init;
  pnfb_pkg::cmd_mode_t cmd_mode;
  logic signed [CW-1:0] sx, sy, wz, hz;
  logic [3:0]          cmd_pen;
  logic [3:0]          cmd_fill;
  logic [2:0]          box_idx;
  logic [2:0]          nbox;
  logic [AW-1:0]       sw_addr;

  logic signed [CW-1:0] bx0, bx1, by0, by1;
  logic signed [CW-1:0] xa_c, xb_c, ya_c, yb_c;
  logic [3:0]          bcol;
  logic                box_empty;
  logic                last_box;

  logic [X_W-1:0]      bxa, bxb, xc;
  logic [Y_W-1:0]      bya, byb, yc;
  logic [3:0]          box_col;
  logic [LIN_W-1:0]    row_base;
  logic [LIN_W-1:0]    lin;
  logic [7:0]          rd_byte;
  logic                rd_out;

  // Corners of the current box, before clipping.
  always_comb begin
    bx0  = sx;
    bx1  = sx;
    by0  = sy;
    by1  = sy;
    bcol = cmd_pen;
    case (cmd_mode)
      pnfb_pkg::MODE_HLINE: bx1 = sx + wz;
      pnfb_pkg::MODE_VLINE: by1 = sy + hz - ONE;
      pnfb_pkg::MODE_FILL: begin
        bx1 = sx + wz;
        by1 = sy + hz;
      end
      pnfb_pkg::MODE_OUTLINE, pnfb_pkg::MODE_OUTFILL: begin
        case (box_idx)
          BOX_TOP: bx1 = sx + wz;
          BOX_BOTTOM: begin
            bx1 = sx + wz;
            by0 = sy + hz;
            by1 = sy + hz;
          end
          BOX_LEFT: by1 = sy + hz - ONE;
          BOX_RIGHT: begin
            bx0 = sx + wz;
            bx1 = sx + wz;
            by1 = sy + hz - ONE;
          end
          default: begin
            bx0  = sx + ONE;
            bx1  = sx + wz - ONE;
            by0  = sy + ONE;
            by1  = sy + hz - ONE;
            bcol = cmd_fill;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign xa_c = (bx0 < ZERO) ? ZERO : bx0;
  assign ya_c = (by0 < ZERO) ? ZERO : by0;
  assign xb_c = (bx1 > XMAX) ? XMAX : bx1;
  assign yb_c = (by1 > YMAX) ? YMAX : by1;
  assign box_empty = (xa_c > xb_c) || (ya_c > yb_c);
  assign last_box  = (box_idx == (nbox - 3'd1));

  assign lin = row_base + LIN_W'(xc);

  always_comb begin
    op_ctl.valid = (state == S_SWEEP) || (state == S_RUN) || (state == S_RD);
    op_ctl.hi    = xc[0];
    case (state)
      S_SWEEP: begin
        op_ctl.kind  = pnfb_pkg::PK_BYTE;
        op_ctl.color = cmd_pen;
        op_addr      = sw_addr;
      end
      S_RD: begin
        op_ctl.kind  = pnfb_pkg::PK_READ;
        op_ctl.color = box_col;
        op_addr      = lin[LIN_W-1:1];
      end
      default: begin
        op_ctl.kind  = pnfb_pkg::PK_NIBBLE;
        op_ctl.color = box_col;
        op_addr      = lin[LIN_W-1:1];
      end
    endcase
  end

  assign cmd.ready     = (state == S_IDLE);
  assign res.valid     = (state == S_DONE) && out_free;
  assign res.read_byte = rd_byte;
  assign res.outside   = rd_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SWEEP;
      init    <= 1'b1;
      sw_addr <= '0;
      cmd_pen <= '0;
      box_idx <= '0;
      rd_out  <= 1'b0;
      rd_byte <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_mode <= pnfb_pkg::cmd_mode_t'(cmd.mode);
            sx       <= {{(CW-11){cmd.x_pos[10]}}, cmd.x_pos};
            sy       <= {{(CW-11){cmd.y_pos[10]}}, cmd.y_pos};
            wz       <= {{(CW-10){1'b0}}, cmd.span_width};
            hz       <= {{(CW-10){1'b0}}, cmd.span_height};
            cmd_pen  <= cmd.pen_color;
            cmd_fill <= cmd.fill_color;
            box_idx  <= '0;
            sw_addr  <= '0;
            rd_byte  <= '0;
            rd_out   <= 1'b0;
            case (pnfb_pkg::cmd_mode_t'(cmd.mode))
              pnfb_pkg::MODE_OUTLINE: nbox <= NBOX_OUTL;
              pnfb_pkg::MODE_OUTFILL: nbox <= NBOX_OFILL;
              default:                nbox <= NBOX_ONE;
            endcase
            if (pnfb_pkg::cmd_mode_t'(cmd.mode) == pnfb_pkg::MODE_CLEAR) begin
              state <= S_SWEEP;
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_SWEEP: begin
          sw_addr <= sw_addr + AW'(1);
          if (sw_addr == AW'(STORE_BYTES - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_SETUP: begin
          bxa     <= xa_c[X_W-1:0];
          bxb     <= xb_c[X_W-1:0];
          bya     <= ya_c[Y_W-1:0];
          byb     <= yb_c[Y_W-1:0];
          box_col <= bcol;
          if (!box_empty) begin
            state <= S_MUL;
          end else if (cmd_mode == pnfb_pkg::MODE_READ) begin
            rd_out <= 1'b1;
            state  <= S_DONE;
          end else if (last_box) begin
            state <= S_DRAIN;
          end else begin
            box_idx <= box_idx + 3'd1;
          end
        end
        S_MUL: begin
          row_base <= LIN_W'(bya) * LIN_W'(SCREEN_WIDTH);
          xc       <= bxa;
          yc       <= bya;
          if (cmd_mode == pnfb_pkg::MODE_READ) begin
            state <= S_RD;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (xc == bxb) begin
            xc <= bxa;
            if (yc == byb) begin
              if (last_box) begin
                state <= S_DRAIN;
              end else begin
                box_idx <= box_idx + 3'd1;
                state   <= S_SETUP;
              end
            end else begin
              yc       <= yc + Y_W'(1);
              row_base <= row_base + LIN_W'(SCREEN_WIDTH);
            end
          end else begin
            xc <= xc + X_W'(1);
          end
        end
        S_RD: state <= S_RD_WAIT;
        S_RD_WAIT: begin
          if (stat.rd_valid) begin
            rd_byte <= stat.rd_data;
            state   <= S_DONE;
          end
        end
        S_DRAIN: begin
          if (!stat.busy) begin
            if (init) begin
              init  <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_op_state: assert property (@(posedge clk) disable iff (rst)
    op_ctl.valid |-> (state == S_SWEEP || state == S_RUN || state == S_RD))
    else $error("pixel operation issued outside a walking state");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !stat.busy)
    else $error("command accepted while a write is still in flight");

  a_res_slot: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> out_free)
    else $error("result produced while the output slot is full");

  a_rd_return: assert property (@(posedge clk) disable iff (rst)
    stat.rd_valid |-> (state == S_RD_WAIT))
    else $error("read data returned with no read pending");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.outside) |-> (res.read_byte == 8'h00))
    else $error("off-screen read carries nonzero data");
endmodule

// File: rtl/core/packed_nibble_framebuffer_drawer.sv
// ---------------------------------------------------------------------------
// packed_nibble_framebuffer_drawer: 4-bit-per-pixel rectangle fill blitter
// Frame store of two pixels per byte with clipped drawing commands.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one drawing command per beat (clear, point, hline, vline,
//   filled rectangle, outline, outlined fill, read byte). result returns
//   exactly one beat per command: the packed byte and the off-screen flag
//   for a read, zeros for every other command.
//   Commands run one at a time. The walker touches one pixel per cycle
//   through a read-modify-write pipe on the frame store; outlines walk
//   four boxes, the outlined fill five. Clear sweeps the store one byte
//   per cycle. After reset the store is swept to zero, one byte per
//   cycle, and cmd.ready stays low until the sweep has drained.
//   The result sits in an output register; cmd.ready rises again as soon
//   as a command has handed off its result, so the next command starts
//   while the receiver stalls. A finished command waits for the register
//   to empty only when the previous result has not been taken yet.
// ---------------------------------------------------------------------------
module packed_nibble_framebuffer_drawer #(
  parameter int SCREEN_WIDTH  = 160,
  parameter int SCREEN_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst,
  pnfb_cmd_if.sink    cmd,
  pnfb_res_if.source  result
);
  localparam int STORE_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  pnfb_pkg::pix_ctl_t  op_ctl;
  logic [AW-1:0]       op_addr;
  pnfb_pkg::rmw_stat_t stat;
  pnfb_pkg::res_t      res;
  logic                out_free;
  logic                out_valid;
  logic [7:0]          out_byte;
  logic                out_outside;

  // Sequencer: clips each box and walks it, one pixel beat per cycle.
  pnfb_seq #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .op_ctl   (op_ctl),
    .op_addr  (op_addr),
    .stat     (stat),
    .out_free (out_free),
    .res      (res)
  );

  // Frame store with its read-modify-write pipe and write forwarding.
  pnfb_rmw #(.DEPTH(STORE_BYTES)) u_rmw (
    .clk    (clk),
    .rst    (rst),
    .op_ctl (op_ctl),
    .op_addr(op_addr),
    .stat   (stat)
  );

  // Output register: free when empty or being drained this cycle.
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (res.valid) begin
      out_byte    <= res.read_byte;
      out_outside <= res.outside;
    end
  end

  assign result.valid        = out_valid;
  assign result.read_byte    = out_byte;
  assign result.read_outside = out_outside;
endmodule
